### src/wpp_pkg.sv
package wpp_pkg;

    localparam int LEN_W  = 33;
    localparam int SIZE_W = 32;

    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    // Fixed positions and lengths of the RIFF layout
    localparam int HDR_RIFF_END  = 3;
    localparam int HDR_END       = 11;
    localparam int HDR_LEN       = 12;
    localparam int CHUNK_HDR_LEN = 8;
    localparam int CHUNK_ID_LEN  = 4;
    localparam int FMT_LEN       = 16;
    localparam int FMT_PCM       = 1;
    localparam int PCM_BITS      = 16;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SHORT       = 4'd1,
        ST_NOT_WAVE    = 4'd2,
        ST_OVERRUN     = 4'd3,
        ST_SMALL_FMT   = 4'd4,
        ST_NON_PCM     = 4'd5,
        ST_MISSING     = 4'd6,
        ST_UNSUPPORTED = 4'd7,
        ST_MISALIGNED  = 4'd8
    } status_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        status_t             status;
        logic [30:0]         sample_rate;
        logic [1:0]          channels;
        logic [4:0]          bits_per_sample;
        logic [LEN_W-1:0]    data_offset;
        logic [SIZE_W-1:0]   data_size;
    } result_t;

endpackage

### src/wpp_channels.sv
interface wpp_byte_if;
    import wpp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

interface wpp_result_if;
    import wpp_pkg::*;

    logic              valid;
    logic              ready;
    logic [3:0]        status;
    logic [30:0]       sample_rate;
    logic [1:0]        channels;
    logic [4:0]        bits_per_sample;
    logic [LEN_W-1:0]  data_offset;
    logic [SIZE_W-1:0] data_size;

    modport source (
        output valid, output status, output sample_rate, output channels,
        output bits_per_sample, output data_offset, output data_size, input ready
    );
    modport sink (
        input valid, input status, input sample_rate, input channels,
        input bits_per_sample, input data_offset, input data_size, output ready
    );
endinterface

### src/wpp_in_reg.sv
module wpp_in_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wpp_pkg::byte_word_t in_word,
    output logic                word_valid,
    output wpp_pkg::byte_word_t word,
    input  logic                take
);
    import wpp_pkg::*;

    logic       valid_reg;
    byte_word_t word_reg;

    assign in_ready   = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

### src/wpp_core.sv
module wpp_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [wpp_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                     word_valid,
    input  wpp_pkg::byte_word_t      word,
    output logic                     take,
    output logic                     load,
    input  logic                     free,
    output wpp_pkg::result_t         result
);
    import wpp_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHDR,
        PH_FMT,
        PH_SKIP,
        PH_TAIL
    } phase_t;

    logic [LEN_W-1:0]  file_length_reg;
    logic [LEN_W-1:0]  pos_reg;
    phase_t            phase_reg, phase_next;
    logic [31:0]       shift_reg, shift_next;
    logic [31:0]       len_reg, len_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic [15:0]       format_reg, format_next;
    logic [15:0]       chan_reg, chan_next;
    logic [31:0]       rate_reg, rate_next;
    logic [15:0]       bits_reg, bits_next;
    logic [LEN_W-1:0]  start_reg, start_next;
    logic [SIZE_W-1:0] dlen_reg, dlen_next;
    logic              have_fmt_reg, have_fmt_next;
    logic              have_data_reg, have_data_next;
    logic              finished_reg;

    logic [LEN_W+1:0]  next_pos;
    logic [LEN_W+1:0]  fl_wide;
    logic              to_tail;
    logic              err_hit;
    status_t           err_code;
    status_t           final_code;
    logic [LEN_W-1:0]  skip_count;
    logic [3:0]        fmt_idx;
    logic [4:0]        fmt_off;
    logic              emit;
    logic              ok;

    assign fl_wide  = {2'b00, file_length_reg};
    assign next_pos = {2'b00, pos_reg} + (LEN_W+2)'(1);
    // A chunk header must fit before the end of the file, else the rest is tail
    assign to_tail  = (next_pos + (LEN_W+2)'(CHUNK_HDR_LEN)) > fl_wide;
    assign fmt_off  = 5'(FMT_LEN) - left_reg[4:0];
    assign fmt_idx  = fmt_off[3:0];

    always_comb
    begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        len_next       = len_reg;
        left_next      = left_reg;
        format_next    = format_reg;
        chan_next      = chan_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        start_next     = start_reg;
        dlen_next      = dlen_reg;
        have_fmt_next  = have_fmt_reg;
        have_data_next = have_data_reg;
        err_hit        = 1'b0;
        err_code       = ST_OK;
        skip_count     = '0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                shift_next = {shift_reg[23:0], word.byte_value};
                if (pos_reg == '0 && file_length_reg < LEN_W'(HDR_LEN))
                begin
                    err_hit  = 1'b1;
                    err_code = ST_SHORT;
                end
                else if (pos_reg == LEN_W'(HDR_RIFF_END) && shift_next != ID_RIFF)
                begin
                    err_hit  = 1'b1;
                    err_code = ST_NOT_WAVE;
                end
                else if (pos_reg == LEN_W'(HDR_END))
                begin
                    if (shift_next != ID_WAVE)
                    begin
                        err_hit  = 1'b1;
                        err_code = ST_NOT_WAVE;
                    end
                    else if (to_tail)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        phase_next = PH_CHDR;
                        left_next  = LEN_W'(CHUNK_HDR_LEN);
                    end
                end
            end
            PH_CHDR:
            begin
                if (left_reg > LEN_W'(CHUNK_ID_LEN))
                begin
                    shift_next = {shift_reg[23:0], word.byte_value};
                end
                else
                begin
                    len_next = {word.byte_value, len_reg[31:8]};
                end
                left_next = left_reg - LEN_W'(1);
                if (left_reg == LEN_W'(1))
                begin
                    skip_count = LEN_W'({1'b0, len_next}) + LEN_W'(len_next[0]);
                    if ((next_pos + (LEN_W+2)'(len_next)) > fl_wide)
                    begin
                        err_hit  = 1'b1;
                        err_code = ST_OVERRUN;
                    end
                    else if (shift_next == ID_FMT)
                    begin
                        if (len_next < 32'(FMT_LEN))
                        begin
                            err_hit  = 1'b1;
                            err_code = ST_SMALL_FMT;
                        end
                        else
                        begin
                            format_next = '0;
                            chan_next   = '0;
                            rate_next   = '0;
                            bits_next   = '0;
                            phase_next  = PH_FMT;
                            left_next   = LEN_W'(FMT_LEN);
                        end
                    end
                    else
                    begin
                        if (shift_next == ID_DATA)
                        begin
                            start_next     = next_pos[LEN_W-1:0];
                            dlen_next      = len_next;
                            have_data_next = 1'b1;
                        end
                        if (skip_count != '0)
                        begin
                            phase_next = PH_SKIP;
                            left_next  = skip_count;
                        end
                        else if (to_tail)
                        begin
                            phase_next = PH_TAIL;
                        end
                        else
                        begin
                            phase_next = PH_CHDR;
                            left_next  = LEN_W'(CHUNK_HDR_LEN);
                        end
                    end
                end
            end
            PH_FMT:
            begin
                unique case (fmt_idx)
                    4'd0:    format_next[7:0]  = word.byte_value;
                    4'd1:    format_next[15:8] = word.byte_value;
                    4'd2:    chan_next[7:0]    = word.byte_value;
                    4'd3:    chan_next[15:8]   = word.byte_value;
                    4'd4:    rate_next[7:0]    = word.byte_value;
                    4'd5:    rate_next[15:8]   = word.byte_value;
                    4'd6:    rate_next[23:16]  = word.byte_value;
                    4'd7:    rate_next[31:24]  = word.byte_value;
                    4'd14:   bits_next[7:0]    = word.byte_value;
                    4'd15:   bits_next[15:8]   = word.byte_value;
                    default: ;
                endcase
                left_next = left_reg - LEN_W'(1);
                if (left_reg == LEN_W'(1))
                begin
                    // Skip the rest of the fmt body and its pad byte
                    skip_count = LEN_W'({1'b0, len_reg}) - LEN_W'(FMT_LEN)
                               + LEN_W'(len_reg[0]);
                    if (format_next != 16'(FMT_PCM))
                    begin
                        err_hit  = 1'b1;
                        err_code = ST_NON_PCM;
                    end
                    else
                    begin
                        have_fmt_next = 1'b1;
                        if (skip_count != '0)
                        begin
                            phase_next = PH_SKIP;
                            left_next  = skip_count;
                        end
                        else if (to_tail)
                        begin
                            phase_next = PH_TAIL;
                        end
                        else
                        begin
                            phase_next = PH_CHDR;
                            left_next  = LEN_W'(CHUNK_HDR_LEN);
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                left_next = left_reg - LEN_W'(1);
                if (left_reg == LEN_W'(1))
                begin
                    if (to_tail)
                    begin
                        phase_next = PH_TAIL;
                    end
                    else
                    begin
                        phase_next = PH_CHDR;
                        left_next  = LEN_W'(CHUNK_HDR_LEN);
                    end
                end
            end
            PH_TAIL:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // End-of-file verdict, taken on the state this byte leaves
    always_comb
    begin
        priority if (next_pos < fl_wide || phase_next == PH_HEADER
                     || phase_next == PH_CHDR || phase_next == PH_FMT)
        begin
            final_code = ST_SHORT;
        end
        else if (!have_fmt_next || !have_data_next)
        begin
            final_code = ST_MISSING;
        end
        else if ((chan_next != 16'd1 && chan_next != 16'd2) || rate_next == '0
                 || rate_next[31] || bits_next != 16'(PCM_BITS))
        begin
            final_code = ST_UNSUPPORTED;
        end
        else if (dlen_next == '0 || dlen_next[0]
                 || (chan_next == 16'd2 && dlen_next[1]))
        begin
            final_code = ST_MISALIGNED;
        end
        else
        begin
            final_code = ST_OK;
        end
    end

    assign take = word_valid && free;
    assign emit = take && !finished_reg && (err_hit || word.last_byte);
    assign load = emit;

    always_comb
    begin
        result.status          = err_hit ? err_code : final_code;
        ok                     = !err_hit && final_code == ST_OK;
        result.sample_rate     = ok ? rate_next[30:0] : '0;
        result.channels        = ok ? chan_next[1:0] : '0;
        result.bits_per_sample = ok ? bits_next[4:0] : '0;
        result.data_offset     = ok ? start_next : '0;
        result.data_size       = ok ? dlen_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            file_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= PH_HEADER;
            shift_reg     <= '0;
            len_reg       <= '0;
            left_reg      <= '0;
            format_reg    <= '0;
            chan_reg      <= '0;
            rate_reg      <= '0;
            bits_reg      <= '0;
            start_reg     <= '0;
            dlen_reg      <= '0;
            have_fmt_reg  <= 1'b0;
            have_data_reg <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (word.last_byte)
            begin
                // Rearm for the next file
                pos_reg       <= '0;
                phase_reg     <= PH_HEADER;
                shift_reg     <= '0;
                len_reg       <= '0;
                left_reg      <= '0;
                format_reg    <= '0;
                chan_reg      <= '0;
                rate_reg      <= '0;
                bits_reg      <= '0;
                start_reg     <= '0;
                dlen_reg      <= '0;
                have_fmt_reg  <= 1'b0;
                have_data_reg <= 1'b0;
                finished_reg  <= 1'b0;
            end
            else
            begin
                pos_reg <= next_pos[LEN_W-1:0];
                if (!finished_reg)
                begin
                    phase_reg     <= phase_next;
                    shift_reg     <= shift_next;
                    len_reg       <= len_next;
                    left_reg      <= left_next;
                    format_reg    <= format_next;
                    chan_reg      <= chan_next;
                    rate_reg      <= rate_next;
                    bits_reg      <= bits_next;
                    start_reg     <= start_next;
                    dlen_reg      <= dlen_next;
                    have_fmt_reg  <= have_fmt_next;
                    have_data_reg <= have_data_next;
                    finished_reg  <= err_hit;
                end
            end
        end
    end

endmodule

### src/wpp_out_reg.sv
module wpp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    output logic              free,
    input  wpp_pkg::result_t  result,
    output logic              out_valid,
    input  logic              out_ready,
    output wpp_pkg::result_t  out_result
);
    import wpp_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign free       = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            result_reg <= result;
        end
    end

endmodule

### src/wav_pcm_header_parser.sv
// Channel   Interface      Role    Word
// stream    wpp_byte_if    sink    one file byte plus end-of-file mark
// result    wpp_result_if  source  status and parsed format, one per file
// cfg       wr_en/wr_data  write   file length in bytes (33 bits)
//
// One byte per clock unless a waiting result stalls the stream. A byte stays in the
// input register until taken; its result, if any, is loaded into the result register as it is taken.
// Reset clears the file length, the parse state and both valid flags.
// While a result waits, the input register still takes one byte; stream.ready
// drops only once that byte is held too.
module wav_pcm_header_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [wpp_pkg::LEN_W-1:0] cfg_wr_data,
    wpp_byte_if.sink                  stream,
    wpp_result_if.source              result
);
    import wpp_pkg::*;

    byte_word_t in_word;
    byte_word_t word;
    logic       word_valid;
    logic       take;
    logic       res_load;
    logic       res_free;
    result_t    core_result;
    result_t    out_result;
    logic       out_valid;

    assign in_word.byte_value = stream.byte_value;
    assign in_word.last_byte  = stream.last_byte;

    wpp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stream.valid),
        .in_ready   (stream.ready),
        .in_word    (in_word),
        .word_valid (word_valid),
        .word       (word),
        .take       (take)
    );

    wpp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .word_valid  (word_valid),
        .word        (word),
        .take        (take),
        .load        (res_load),
        .free        (res_free),
        .result      (core_result)
    );

    wpp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_load),
        .free       (res_free),
        .result     (core_result),
        .out_valid  (out_valid),
        .out_ready  (result.ready),
        .out_result (out_result)
    );

    assign result.valid           = out_valid;
    assign result.status          = out_result.status;
    assign result.sample_rate     = out_result.sample_rate;
    assign result.channels        = out_result.channels;
    assign result.bits_per_sample = out_result.bits_per_sample;
    assign result.data_offset     = out_result.data_offset;
    assign result.data_size       = out_result.data_size;

    ok_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == ST_OK) |->
        ((result.channels == 2'd1 || result.channels == 2'd2)
         && result.bits_per_sample == 5'(PCM_BITS) && result.data_size != '0))
        else $error("ok result with unsupported format fields");

    error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != ST_OK) |->
        (result.sample_rate == '0 && result.channels == '0
         && result.bits_per_sample == '0 && result.data_offset == '0
         && result.data_size == '0))
        else $error("error result carries nonzero fields");

    ready_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !stream.ready |-> (word_valid && !take))
        else $error("input stalled with room in the input register");

    load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (res_free && take))
        else $error("result loaded while result register busy");

endmodule

### tb/sv/tb_wav_pcm_header_parser.sv
module tb_wav_pcm_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import wpp_pkg::*;

    localparam int  CYCLE_LIMIT  = 1_000_000;
    localparam int  SETTLE       = 6;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  RANDOM_WORDS = 1800;
    localparam int  MIN_FILES    = 14;
    localparam logic [31:0] ID_LIST = 32'h4C49_5354;

    typedef enum logic [2:0] {
        W_HEADER,
        W_CHUNK_HDR,
        W_FMT_BODY,
        W_SKIP,
        W_TAIL
    } walk_phase_t;

    // One directed word; known marks a row whose result is spelled out here
    typedef struct packed {
        logic             set_len;
        logic [LEN_W-1:0] len;
        logic [7:0]       b;
        logic             last;
        logic             known;
        logic [3:0]       st;
    } probe_t;

    typedef struct {
        bit      known;
        result_t value;
    } answer_t;

    localparam probe_t PROBES [21] = '{
        // reset file length is zero: the first byte is already short
        '{1'b0, 33'd0, 8'h00, 1'b0, 1'b1, ST_SHORT},
        '{1'b0, 33'd0, 8'hFF, 1'b1, 1'b0, ST_OK},
        // largest length, "RIFX" fails the RIFF check at byte 3
        '{1'b1, 33'h1_FFFF_FFFF, 8'h52, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h49, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h46, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h58, 1'b0, 1'b1, ST_NOT_WAVE},
        '{1'b0, 33'd0, 8'h00, 1'b1, 1'b0, ST_OK},
        // bare 12-byte header: no chunks at all
        '{1'b1, 33'd12, 8'h52, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h49, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h46, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h46, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'hFF, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h00, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h80, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h7F, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h57, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h41, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h56, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h45, 1'b1, 1'b1, ST_MISSING},
        // stream ends inside the header
        '{1'b0, 33'd0, 8'h52, 1'b0, 1'b0, ST_OK},
        '{1'b0, 33'd0, 8'h49, 1'b1, 1'b1, ST_SHORT}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [LEN_W-1:0]    cfg_wr_data;

    wpp_byte_if   stream_ch ();
    wpp_result_if result_ch ();

    wav_pcm_header_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (stream_ch),
        .result      (result_ch)
    );

    // Parser image kept alongside the block
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  pos;
    walk_phase_t       walk;
    logic [31:0]       id_shift;
    logic [31:0]       ck_len;
    logic [LEN_W-1:0]  ck_left;
    logic [15:0]       fmt_code;
    logic [15:0]       chan_cnt;
    logic [31:0]       rate;
    logic [15:0]       bits_cnt;
    logic [LEN_W-1:0]  d_start;
    logic [31:0]       d_len;
    bit                got_fmt;
    bit                got_data;
    bit                done;

    result_t     pending_results [$];
    answer_t     fixed_answers [$];
    logic [7:0]  file_bytes [$];
    string       field_name [0:5] = '{"status", "sample_rate", "channels",
                                      "bits_per_sample", "data_offset", "data_size"};

    int  errors;
    int  words_in;
    int  results_seen;
    int  random_words;
    int  files_sent;
    int  len_writes;
    int  cycle_count;
    bit  hold_req;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_walk();
        pos = '0;
        walk = W_HEADER;
        id_shift = '0;
        ck_len = '0;
        ck_left = '0;
        fmt_code = '0;
        chan_cnt = '0;
        rate = '0;
        bits_cnt = '0;
        d_start = '0;
        d_len = '0;
        got_fmt = 0;
        got_data = 0;
        done = 0;
    endfunction

    function automatic void next_chunk(input logic [63:0] at);
        if (at + 64'd8 > {31'd0, len_reg}) begin
            walk = W_TAIL;
        end
        else begin
            walk = W_CHUNK_HDR;
            ck_left = LEN_W'(CHUNK_HDR_LEN);
        end
    endfunction

    function automatic void skip_or_next(input logic [63:0] at, input logic [63:0] count);
        if (count == 0) begin
            next_chunk(at);
        end
        else begin
            walk = W_SKIP;
            ck_left = count[LEN_W-1:0];
        end
    endfunction

    function automatic result_t make_result(input status_t st);
        result_t r;
        r = '0;
        r.status = st;
        if (st == ST_OK) begin
            r.sample_rate = rate[30:0];
            r.channels = chan_cnt[1:0];
            r.bits_per_sample = bits_cnt[4:0];
            r.data_offset = d_start;
            r.data_size = d_len;
        end
        done = 1;
        return r;
    endfunction

    // Advance the parser image by one byte; returns 1 when the byte yields a result
    function automatic bit wav_step(input logic [7:0] b, input bit last, output result_t r);
        logic [63:0] here;
        logic [63:0] nxt;
        logic [63:0] span;
        logic [63:0] flen;
        int          idx;
        status_t     st;
        bit          hit;
        here = {31'd0, pos};
        nxt = here + 64'd1;
        flen = {31'd0, len_reg};
        st = ST_OK;
        hit = 0;
        r = '0;
        if (!done) begin
            case (walk)
                W_HEADER: begin
                    if (here == 0 && flen < HDR_LEN) begin
                        st = ST_SHORT;
                    end
                    else begin
                        id_shift = {id_shift[23:0], b};
                        if (here == HDR_RIFF_END && id_shift != ID_RIFF) begin
                            st = ST_NOT_WAVE;
                        end
                        else if (here == HDR_END) begin
                            if (id_shift != ID_WAVE) st = ST_NOT_WAVE;
                            else next_chunk(64'(HDR_LEN));
                        end
                    end
                end
                W_CHUNK_HDR: begin
                    idx = CHUNK_HDR_LEN - int'(ck_left);
                    if (idx < CHUNK_ID_LEN) id_shift = {id_shift[23:0], b};
                    else ck_len = {b, ck_len[31:8]};
                    ck_left = ck_left - 1'b1;
                    if (ck_left == 0) begin
                        span = {32'd0, ck_len};
                        if (nxt + span > flen) begin
                            st = ST_OVERRUN;
                        end
                        else if (id_shift == ID_FMT) begin
                            if (span < FMT_LEN) begin
                                st = ST_SMALL_FMT;
                            end
                            else begin
                                fmt_code = '0;
                                chan_cnt = '0;
                                rate = '0;
                                bits_cnt = '0;
                                walk = W_FMT_BODY;
                                ck_left = LEN_W'(FMT_LEN);
                            end
                        end
                        else begin
                            if (id_shift == ID_DATA) begin
                                d_start = nxt[LEN_W-1:0];
                                d_len = ck_len;
                                got_data = 1;
                            end
                            skip_or_next(nxt, span + ck_len[0]);
                        end
                    end
                end
                W_FMT_BODY: begin
                    idx = FMT_LEN - int'(ck_left);
                    if (idx < 2) fmt_code[8*idx +: 8] = b;
                    else if (idx < 4) chan_cnt[8*(idx-2) +: 8] = b;
                    else if (idx < 8) rate[8*(idx-4) +: 8] = b;
                    else if (idx >= 14) bits_cnt[8*(idx-14) +: 8] = b;
                    ck_left = ck_left - 1'b1;
                    if (ck_left == 0) begin
                        if (fmt_code != FMT_PCM) begin
                            st = ST_NON_PCM;
                        end
                        else begin
                            got_fmt = 1;
                            skip_or_next(nxt, {32'd0, ck_len} - FMT_LEN + ck_len[0]);
                        end
                    end
                end
                W_SKIP: begin
                    ck_left = ck_left - 1'b1;
                    if (ck_left == 0) next_chunk(nxt);
                end
                default: ;
            endcase
            if (st != ST_OK) begin
                r = make_result(st);
                hit = 1;
            end
            else if (last) begin
                if (here + 64'd1 < flen || walk == W_HEADER || walk == W_CHUNK_HDR ||
                    walk == W_FMT_BODY)
                    st = ST_SHORT;
                else if (!got_fmt || !got_data)
                    st = ST_MISSING;
                else if ((chan_cnt != 1 && chan_cnt != 2) || rate == 0 || rate[31] ||
                         bits_cnt != PCM_BITS)
                    st = ST_UNSUPPORTED;
                else if (d_len == 0 || d_len % (chan_cnt * 2) != 0)
                    st = ST_MISALIGNED;
                else
                    st = ST_OK;
                r = make_result(st);
                hit = 1;
            end
        end
        if (last) clear_walk();
        else pos = pos + 1'b1;
        return hit;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        file_bytes.insert(file_bytes.size(), v);
    endfunction

    function automatic void push_be32(input logic [31:0] v);
        for (int i = 3; i >= 0; i--) add_byte(v[8*i +: 8]);
    endfunction

    function automatic void push_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
    endfunction

    function automatic void push_noise(input int n);
        for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
    endfunction

    // Mostly well-formed files with random content, some broken on purpose
    task automatic build_file(input bit wreck_head, output logic [LEN_W-1:0] flen);
        int          count;
        int          pick;
        int          r;
        int          align;
        int          cut;
        logic [31:0] size;
        logic [31:0] rval;
        logic [15:0] ch;
        file_bytes.delete();
        align = 4;
        push_be32(ID_RIFF);
        push_le($urandom, 4);
        push_be32(ID_WAVE);
        count = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 4) : 1;
        for (int k = 0; k < count; k++) begin
            if (k < 2 && $urandom_range(0, 9) < 8) pick = k;
            else pick = $urandom_range(0, 2);
            case (pick)
                0: begin
                    r = $urandom_range(0, 9);
                    if (r < 6) size = FMT_LEN;
                    else if (r == 6) size = 18;
                    else if (r == 7) size = 17;
                    else if (r == 8) size = $urandom_range(19, 24);
                    else size = $urandom_range(0, FMT_LEN - 1);
                    push_be32(ID_FMT);
                    push_le(size, 4);
                    if (size >= FMT_LEN) begin
                        push_le(($urandom_range(0, 9) < 9) ? FMT_PCM : $urandom, 2);
                        ch = 16'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 2) : $urandom);
                        push_le(ch, 2);
                        r = $urandom_range(0, 9);
                        if (r < 7) rval = $urandom_range(8000, 192000);
                        else if (r == 7) rval = 0;
                        else if (r == 8) rval = $urandom | 32'h8000_0000;
                        else rval = $urandom;
                        push_le(rval, 4);
                        push_noise(6);
                        push_le(($urandom_range(0, 9) < 8) ? PCM_BITS : $urandom, 2);
                        push_noise(size - FMT_LEN);
                        align = (ch == 1 || ch == 2) ? ch * 2 : 4;
                    end
                    else begin
                        push_noise(size);
                    end
                end
                1: begin
                    r = $urandom_range(0, 9);
                    if (r < 7) size = align * $urandom_range(1, 4);
                    else if (r == 7) size = 0;
                    else if (r == 8) size = $urandom_range(1, 9);
                    else size = align * $urandom_range(1, 3) + 1;
                    push_be32(ID_DATA);
                    push_le(size, 4);
                    push_noise(size);
                end
                default: begin
                    size = $urandom_range(0, 9);
                    push_be32(($urandom_range(0, 1) == 0) ? ID_LIST : $urandom);
                    push_le(size, 4);
                    push_noise(size);
                end
            endcase
            if (size[0]) push_noise(1);
        end
        flen = LEN_W'(file_bytes.size());
        r = $urandom_range(0, 19);
        if (r >= 12 && r <= 14) begin
            // tail too short for a chunk header
            push_noise($urandom_range(1, 7));
            flen = LEN_W'(file_bytes.size());
        end
        else if (r == 15 || r == 16) begin
            flen = LEN_W'(file_bytes.size() + $urandom_range(1, 16));
        end
        else if (r == 17) begin
            flen = LEN_W'(file_bytes.size() - $urandom_range(1, 8));
        end
        else if (r == 18) begin
            flen = {1'($urandom_range(0, 1)), $urandom};
        end
        else if (r == 19) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
        if ($urandom_range(0, 9) == 0)
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        if (wreck_head) begin
            // fail at byte 3, then keep the stream busy behind the stuck result
            file_bytes[0] = 8'h00;
            push_noise(60);
        end
    endtask

    task automatic send_word(input logic [7:0] b, input bit last, input bit known,
                             input status_t st, input bit steady);
        int      n;
        answer_t a;
        n = steady ? 0 : pick_gap();
        if (n > 0) begin
            stream_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        stream_ch.valid <= 1'b1;
        stream_ch.byte_value <= b;
        stream_ch.last_byte <= last;
        a.known = known;
        a.value = '0;
        a.value.status = st;
        fixed_answers.insert(fixed_answers.size(), a);
        do @(posedge clk); while (!stream_ch.ready);
    endtask

    // Write only once every result is out and the last word has drained
    task automatic write_length(input logic [LEN_W-1:0] v);
        stream_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        len_writes++;
    endtask

    always @(posedge clk) begin
        answer_t a;
        result_t r;
        bit      hit;
        if (rst_n) begin
            if (cfg_wr_en) len_reg = cfg_wr_data;
            if (stream_ch.valid && stream_ch.ready) begin
                words_in++;
                a = fixed_answers.pop_front();
                hit = wav_step(stream_ch.byte_value, stream_ch.last_byte, r);
                if (a.known) pending_results.insert(pending_results.size(), a.value);
                else if (hit) pending_results.insert(pending_results.size(), r);
            end
        end
    end

    always @(posedge clk) begin
        result_t     want;
        logic [63:0] w [0:5];
        logic [63:0] g [0:5];
        if (rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, result_ch.status);
            end
            else begin
                want = pending_results.pop_front();
                w[0] = 64'(want.status);          g[0] = 64'(result_ch.status);
                w[1] = 64'(want.sample_rate);     g[1] = 64'(result_ch.sample_rate);
                w[2] = 64'(want.channels);        g[2] = 64'(result_ch.channels);
                w[3] = 64'(want.bits_per_sample); g[3] = 64'(result_ch.bits_per_sample);
                w[4] = 64'(want.data_offset);     g[4] = 64'(result_ch.data_offset);
                w[5] = 64'(want.data_size);       g[5] = 64'(result_ch.data_size);
                for (int i = 0; i < 6; i++) begin
                    if (g[i] !== w[i]) begin
                        errors++;
                        $display("%0t: %s expected %0h actual %0h",
                                 $time, field_name[i], w[i], g[i]);
                    end
                end
            end
        end
    end

    // Result sink: random stalls, calm stretches, and a long hold on each request
    initial begin
        int gap_left;
        int hold_left;
        int mode_left;
        bit calm;
        gap_left = 0;
        hold_left = 0;
        mode_left = 0;
        calm = 0;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (hold_req) begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (gap_left > 0) begin
                gap_left--;
                result_ch.ready <= 1'b0;
            end
            else begin
                result_ch.ready <= 1'b1;
                if (!calm) gap_left = pick_gap();
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [LEN_W-1:0] flen;
        bit               wreck;
        bit               steady;
        probe_t           p;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        stream_ch.valid <= 1'b0;
        stream_ch.byte_value <= '0;
        stream_ch.last_byte <= 1'b0;
        len_reg = '0;
        clear_walk();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PROBES[i]) begin
            p = PROBES[i];
            if (p.set_len) write_length(p.len);
            send_word(p.b, p.last, p.known, status_t'(p.st), 1'b0);
        end

        while (random_words < RANDOM_WORDS || files_sent < MIN_FILES) begin
            wreck = (files_sent == 3 || files_sent == 12);
            build_file(wreck, flen);
            write_length(flen);
            if (wreck) hold_req = 1;
            steady = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < file_bytes.size(); i++) begin
                send_word(file_bytes[i], i == file_bytes.size() - 1, 0, ST_OK, steady);
                random_words++;
            end
            files_sent++;
        end

        stream_ch.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4 * SETTLE) @(posedge clk);

        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("Sent %0d directed words and %0d random files, %0d bytes in, %0d results checked",
                 $size(PROBES), files_sent, words_in, results_seen);
        $display("File length register written %0d times, %0d mismatches", len_writes, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
